// ===== sv/superpixel_window_assign_macros.svh =====
// assertion helpers shared by the superpixel assignment block
`ifndef SUPERPIXEL_WINDOW_ASSIGN_MACROS_SVH
`define SUPERPIXEL_WINDOW_ASSIGN_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPWA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SPWA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/spwa_pkg.sv =====
`default_nettype none
package spwa_pkg;

  localparam int MaxWidth  = 512;
  localparam int MaxHeight = 512;
  localparam int MaxRadius = 64;

  localparam int StoreAw  = 18;
  localparam int CoordW   = 9;
  localparam int DimW     = 10;
  localparam int RadW     = 7;
  localparam int ShiftW   = 4;
  localparam int WeightAw = 8;
  localparam int KeyW     = 16;
  localparam int NumW     = 16;
  localparam int ColW     = 8;
  localparam int L1W      = 10;
  localparam int PaddrW   = 4;
  localparam int PdataW   = 32;

  localparam logic [KeyW+NumW-1:0] BestInit = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    FUNC_LOAD_PIXEL,
    FUNC_LOAD_WEIGHT,
    FUNC_SCAN,
    FUNC_READ
  } func_e;

  typedef enum logic [1:0] {
    REG_WIDTH,
    REG_HEIGHT,
    REG_RADIUS,
    REG_SHIFT
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BOUNDS,
    ST_BASE,
    ST_SCAN,
    ST_DRAIN,
    ST_READ
  } state_e;

  // effective configuration, already clamped to the supported range
  typedef struct packed {
    logic [DimW-1:0]   width;
    logic [DimW-1:0]   height;
    logic [RadW-1:0]   radius;
    logic [ShiftW-1:0] shift;
  } cfg_t;

  function automatic logic [ColW-1:0] absdiff8(input logic [ColW-1:0] a,
                                               input logic [ColW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [CoordW-1:0] absdiff9(input logic [CoordW-1:0] a,
                                                 input logic [CoordW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== sv/spwa_cfg_regs.sv =====
`default_nettype none
module spwa_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [spwa_pkg::PaddrW-1:0] paddr,
  input  wire logic [spwa_pkg::PdataW-1:0] pwdata,
  output logic      [spwa_pkg::PdataW-1:0] prdata,
  output spwa_pkg::cfg_t                   cfg_o
);

  logic [spwa_pkg::DimW-1:0]   width_q, height_q;
  logic [spwa_pkg::RadW-1:0]   radius_q;
  logic [spwa_pkg::ShiftW-1:0] shift_q;
  logic                        wr_en;
  spwa_pkg::reg_e              reg_sel;

  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = spwa_pkg::reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= spwa_pkg::DimW'(512);
      height_q <= spwa_pkg::DimW'(512);
      radius_q <= spwa_pkg::RadW'(16);
      shift_q  <= spwa_pkg::ShiftW'(7);
    end else if (wr_en) begin
      case (reg_sel)
        spwa_pkg::REG_WIDTH:  width_q  <= pwdata[spwa_pkg::DimW-1:0];
        spwa_pkg::REG_HEIGHT: height_q <= pwdata[spwa_pkg::DimW-1:0];
        spwa_pkg::REG_RADIUS: radius_q <= pwdata[spwa_pkg::RadW-1:0];
        spwa_pkg::REG_SHIFT:  shift_q  <= pwdata[spwa_pkg::ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      spwa_pkg::REG_WIDTH:  prdata = spwa_pkg::PdataW'(width_q);
      spwa_pkg::REG_HEIGHT: prdata = spwa_pkg::PdataW'(height_q);
      spwa_pkg::REG_RADIUS: prdata = spwa_pkg::PdataW'(radius_q);
      spwa_pkg::REG_SHIFT:  prdata = spwa_pkg::PdataW'(shift_q);
      default:              prdata = '0;
    endcase
  end

  // zero size acts as one, oversize acts as the maximum
  always_comb begin
    if (width_q == '0) cfg_o.width = spwa_pkg::DimW'(1);
    else if (width_q > spwa_pkg::DimW'(spwa_pkg::MaxWidth))
      cfg_o.width = spwa_pkg::DimW'(spwa_pkg::MaxWidth);
    else cfg_o.width = width_q;
    if (height_q == '0) cfg_o.height = spwa_pkg::DimW'(1);
    else if (height_q > spwa_pkg::DimW'(spwa_pkg::MaxHeight))
      cfg_o.height = spwa_pkg::DimW'(spwa_pkg::MaxHeight);
    else cfg_o.height = height_q;
    if (radius_q > spwa_pkg::RadW'(spwa_pkg::MaxRadius))
      cfg_o.radius = spwa_pkg::RadW'(spwa_pkg::MaxRadius);
    else cfg_o.radius = radius_q;
    cfg_o.shift = shift_q;
  end

endmodule
`default_nettype wire

// ===== sv/superpixel_window_assign.sv =====
// load pixel and load weight: written on accept, the block stays idle for the next item, no result
// read: the best word is registered on accept and copied to the outputs once they are free; busy until then
// scan: after the accept, a bounds state and a base state, then one window pixel per cycle in the
//   scan state, then a drain state until the pipeline is empty; the best-word memory port takes one pixel a cycle
// empty window: the scan ends in the bounds state, which returns to idle
// reset: a clearing pass writes all 262144 best words, input not ready meanwhile
`default_nettype none
`include "superpixel_window_assign_macros.svh"
module superpixel_window_assign (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    func_i,
  input  wire logic [spwa_pkg::StoreAw-1:0]  pixel_index_i,
  input  wire logic [spwa_pkg::ColW-1:0]     red_i,
  input  wire logic [spwa_pkg::ColW-1:0]     green_i,
  input  wire logic [spwa_pkg::ColW-1:0]     blue_i,
  input  wire logic [spwa_pkg::CoordW-1:0]   center_row_i,
  input  wire logic [spwa_pkg::CoordW-1:0]   center_col_i,
  input  wire logic [spwa_pkg::NumW-1:0]     cluster_number_i,
  input  wire logic [spwa_pkg::WeightAw-1:0] table_index_i,
  input  wire logic [spwa_pkg::KeyW-1:0]     weight_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [spwa_pkg::NumW-1:0]     label_o,
  output logic      [spwa_pkg::KeyW-1:0]     best_key_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [spwa_pkg::PaddrW-1:0]   paddr,
  input  wire logic [spwa_pkg::PdataW-1:0]   pwdata,
  output logic      [spwa_pkg::PdataW-1:0]   prdata,
  output logic                               pready
);

  localparam int Depth = 2 ** spwa_pkg::StoreAw;
  localparam int WordW = spwa_pkg::KeyW + spwa_pkg::NumW;
  localparam int PixW  = 3 * spwa_pkg::ColW;

  spwa_pkg::cfg_t   cfg;
  spwa_pkg::state_e state_q, state_d;
  spwa_pkg::func_e  func;

  logic accept;

  // item operands
  logic [spwa_pkg::CoordW-1:0] c_row_q, c_col_q;
  logic [spwa_pkg::ColW-1:0]   c_r_q, c_g_q, c_b_q;
  logic [spwa_pkg::NumW-1:0]   num_q;

  // window bounds and scan position
  logic [spwa_pkg::CoordW-1:0]  y_lo_q, y_hi_q, x_lo_q, x_hi_q;
  logic [spwa_pkg::CoordW-1:0]  y_q, y_d, x_q, x_d;
  logic [spwa_pkg::StoreAw-1:0] base_q, base_d;
  logic [spwa_pkg::CoordW-1:0]  y_lo_c, x_lo_c;
  logic [spwa_pkg::DimW-1:0]    y_hi_c, x_hi_c, y_hi_full, x_hi_full, h_m1, w_m1;
  logic                         win_empty;
  logic                         bounds_ld, base_ld, issue;

  logic [spwa_pkg::StoreAw-1:0] clr_cnt_q;

  // pipeline
  logic                          s1_v_q, s2_v_q;
  logic [spwa_pkg::StoreAw-1:0]  s1_addr_q, s2_addr_q, scan_addr;
  logic [spwa_pkg::KeyW-1:0]     s2_key_q, key_c, shifted_c;
  logic [WordW-1:0]              s2_best_q, new_word;
  logic [spwa_pkg::L1W-1:0]      l1_c;
  logic [spwa_pkg::WeightAw-1:0] man_c;
  logic                          upd;

  // memories
  logic [PixW-1:0]                pix_mem [Depth];
  logic [WordW-1:0]               best_mem [Depth];
  logic [spwa_pkg::KeyW-1:0]      wt_mem [2 ** spwa_pkg::WeightAw];
  logic [PixW-1:0]                pix_rdata_q;
  logic [WordW-1:0]               best_rdata_q;
  logic [spwa_pkg::KeyW-1:0]      wt_rdata_q;
  logic                           best_we, best_re;
  logic [spwa_pkg::StoreAw-1:0]   best_waddr, best_raddr;
  logic [WordW-1:0]               best_wdata;

  logic out_ld;

  spwa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign pready     = 1'b1;
  assign in_ready_o = (state_q == spwa_pkg::ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign func       = spwa_pkg::func_e'(func_i);

  // window clipped to the image
  always_comb begin
    y_lo_c    = (c_row_q > spwa_pkg::CoordW'(cfg.radius))
                ? c_row_q - spwa_pkg::CoordW'(cfg.radius) : '0;
    x_lo_c    = (c_col_q > spwa_pkg::CoordW'(cfg.radius))
                ? c_col_q - spwa_pkg::CoordW'(cfg.radius) : '0;
    y_hi_full = spwa_pkg::DimW'(c_row_q) + spwa_pkg::DimW'(cfg.radius);
    x_hi_full = spwa_pkg::DimW'(c_col_q) + spwa_pkg::DimW'(cfg.radius);
    h_m1      = cfg.height - spwa_pkg::DimW'(1);
    w_m1      = cfg.width - spwa_pkg::DimW'(1);
    y_hi_c    = (y_hi_full > h_m1) ? h_m1 : y_hi_full;
    x_hi_c    = (x_hi_full > w_m1) ? w_m1 : x_hi_full;
    win_empty = (spwa_pkg::DimW'(y_lo_c) > y_hi_c) || (spwa_pkg::DimW'(x_lo_c) > x_hi_c);
  end

  assign scan_addr = base_q + spwa_pkg::StoreAw'(x_q);
  assign man_c     = spwa_pkg::WeightAw'(spwa_pkg::absdiff9(y_q, c_row_q))
                   + spwa_pkg::WeightAw'(spwa_pkg::absdiff9(x_q, c_col_q));

  always_comb begin
    state_d   = state_q;
    bounds_ld = 1'b0;
    base_ld   = 1'b0;
    issue     = 1'b0;
    out_ld    = 1'b0;
    y_d       = y_q;
    x_d       = x_q;
    base_d    = base_q;
    case (state_q)
      spwa_pkg::ST_CLEAR: begin
        if (&clr_cnt_q) state_d = spwa_pkg::ST_IDLE;
      end
      spwa_pkg::ST_IDLE: begin
        if (accept && func == spwa_pkg::FUNC_SCAN) state_d = spwa_pkg::ST_BOUNDS;
        if (accept && func == spwa_pkg::FUNC_READ) state_d = spwa_pkg::ST_READ;
      end
      spwa_pkg::ST_BOUNDS: begin
        bounds_ld = 1'b1;
        state_d   = win_empty ? spwa_pkg::ST_IDLE : spwa_pkg::ST_BASE;
      end
      spwa_pkg::ST_BASE: begin
        base_ld = 1'b1;
        base_d  = spwa_pkg::StoreAw'(y_lo_q) * spwa_pkg::StoreAw'(cfg.width);
        y_d     = y_lo_q;
        x_d     = x_lo_q;
        state_d = spwa_pkg::ST_SCAN;
      end
      spwa_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (x_q == x_hi_q) begin
          x_d = x_lo_q;
          if (y_q == y_hi_q) begin
            state_d = spwa_pkg::ST_DRAIN;
          end else begin
            y_d    = y_q + spwa_pkg::CoordW'(1);
            base_d = base_q + spwa_pkg::StoreAw'(cfg.width);
          end
        end else begin
          x_d = x_q + spwa_pkg::CoordW'(1);
        end
      end
      spwa_pkg::ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) state_d = spwa_pkg::ST_IDLE;
      end
      spwa_pkg::ST_READ: begin
        if (!out_valid_o || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = spwa_pkg::ST_IDLE;
        end
      end
      default: state_d = spwa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spwa_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == spwa_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + spwa_pkg::StoreAw'(1);
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      if (out_ld) out_valid_o <= 1'b1;
      else if (out_ready_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && func == spwa_pkg::FUNC_SCAN) begin
      c_row_q <= center_row_i;
      c_col_q <= center_col_i;
      c_r_q   <= red_i;
      c_g_q   <= green_i;
      c_b_q   <= blue_i;
      num_q   <= cluster_number_i;
    end
    if (bounds_ld) begin
      y_lo_q <= y_lo_c;
      x_lo_q <= x_lo_c;
      y_hi_q <= spwa_pkg::CoordW'(y_hi_c);
      x_hi_q <= spwa_pkg::CoordW'(x_hi_c);
    end
    if (base_ld || issue) begin
      y_q    <= y_d;
      x_q    <= x_d;
      base_q <= base_d;
    end
    s1_addr_q <= scan_addr;
    s2_addr_q <= s1_addr_q;
    s2_key_q  <= key_c;
    s2_best_q <= best_rdata_q;
    if (out_ld) begin
      label_o    <= best_rdata_q[spwa_pkg::NumW-1:0];
      best_key_o <= best_rdata_q[WordW-1:spwa_pkg::NumW];
    end
  end

  // key of the pixel whose memory data arrived this cycle
  always_comb begin
    l1_c = spwa_pkg::L1W'(spwa_pkg::absdiff8(pix_rdata_q[23:16], c_r_q))
         + spwa_pkg::L1W'(spwa_pkg::absdiff8(pix_rdata_q[15:8], c_g_q))
         + spwa_pkg::L1W'(spwa_pkg::absdiff8(pix_rdata_q[7:0], c_b_q));
    shifted_c = spwa_pkg::KeyW'(l1_c) << cfg.shift;
    key_c     = shifted_c + wt_rdata_q;
  end

  assign new_word = {s2_key_q, num_q};
  assign upd      = s2_v_q && (s2_best_q > new_word);

  // best-word write port: clearing pass, scan update, pixel load
  always_comb begin
    best_we    = 1'b0;
    best_waddr = s2_addr_q;
    best_wdata = new_word;
    if (state_q == spwa_pkg::ST_CLEAR) begin
      best_we    = 1'b1;
      best_waddr = clr_cnt_q;
      best_wdata = spwa_pkg::BestInit;
    end else if (upd) begin
      best_we = 1'b1;
    end else if (accept && func == spwa_pkg::FUNC_LOAD_PIXEL) begin
      best_we    = 1'b1;
      best_waddr = pixel_index_i;
      best_wdata = spwa_pkg::BestInit;
    end
  end

  assign best_re    = issue || (accept && func == spwa_pkg::FUNC_READ);
  assign best_raddr = issue ? scan_addr : pixel_index_i;

  always_ff @(posedge clk_i) begin
    if (best_we) best_mem[best_waddr] <= best_wdata;
    if (best_re) best_rdata_q <= best_mem[best_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && func == spwa_pkg::FUNC_LOAD_PIXEL)
      pix_mem[pixel_index_i] <= {red_i, green_i, blue_i};
    if (issue) pix_rdata_q <= pix_mem[scan_addr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && func == spwa_pkg::FUNC_LOAD_WEIGHT) wt_mem[table_index_i] <= weight_value_i;
    if (issue) wt_rdata_q <= wt_mem[man_c];
  end

  `SPWA_ASSERT_IMP(a_no_accept_busy, in_ready_o, state_q == spwa_pkg::ST_IDLE, "ready while busy")
  `SPWA_ASSERT_NEXT(a_pipe_advance, s1_v_q, s2_v_q, "scan pipeline lost a pixel")
  `SPWA_ASSERT_IMP(a_upd_in_scan, upd,
    state_q == spwa_pkg::ST_SCAN || state_q == spwa_pkg::ST_DRAIN, "update outside scan")

endmodule
`default_nettype wire
